// ----- rtl/core/ssts_pkg.sv -----
// Package with shared types for the subset sum two-way split block.
package ssts_pkg;

    typedef struct packed {
        logic upd_start;
        logic fin_start;
    } ssts_cmd_t;

    typedef struct packed {
        logic clr_done;
        logic upd_done;
        logic fin_done;
    } ssts_status_t;

endpackage

// ----- rtl/core/ssts_ram.sv -----
// Generic single-port-write, one-read RAM with registered read data.
module ssts_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ----- rtl/core/ssts_ctrl.sv -----
// Controller state machine that sequences clearing, update and finish phases.
module ssts_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic                  last_item,
    input  logic                  room,
    output logic                  busy,
    output ssts_pkg::ssts_cmd_t   cmd,
    input  ssts_pkg::ssts_status_t sts
);
    import ssts_pkg::*;

    typedef enum logic [4:0] {
        S_CLR  = 5'b00001,
        S_IDLE = 5'b00010,
        S_UPD  = 5'b00100,
        S_FIN  = 5'b01000,
        S_WAIT = 5'b10000
    } state_t;

    state_t state_reg, state_next;
    logic   last_reg, last_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLR;
            last_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            last_reg  <= last_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        last_next  = last_reg;
        cmd        = '0;
        busy       = 1'b1;
        unique case (state_reg)
            S_CLR:
            begin
                if (sts.clr_done)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                busy = 1'b0;
                if (start)
                begin
                    last_next = last_item;
                    if (room)
                    begin
                        cmd.upd_start = 1'b1;
                        state_next    = S_UPD;
                    end
                    else if (last_item)
                    begin
                        cmd.fin_start = 1'b1;
                        state_next    = S_FIN;
                    end
                end
            end
            S_UPD:
            begin
                if (sts.upd_done)
                begin
                    if (last_reg)
                    begin
                        state_next = S_WAIT;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            S_FIN:
            begin
                if (sts.fin_done)
                begin
                    state_next = S_CLR;
                end
            end
            S_WAIT:
            begin
                cmd.fin_start = 1'b1;
                state_next    = S_FIN;
            end
            default:
            begin
                state_next = S_CLR;
            end
        endcase
    end
endmodule

// ----- rtl/core/ssts_dp.sv -----
// Datapath with bitmap, traceback table, duration store and result sequencing.
module ssts_dp #(
    parameter int MAX_SUM   = 4096,
    parameter int MAX_ITEMS = 64
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic [11:0]            capacity,
    input  logic [11:0]            duration,
    input  logic                   accept,
    output logic                   room,
    input  ssts_pkg::ssts_cmd_t    cmd,
    output ssts_pkg::ssts_status_t sts,
    output logic                   result_valid,
    output logic [5:0]             item_index,
    output logic                   group,
    output logic [17:0]            start_time,
    output logic                   last_result
);
    import ssts_pkg::*;

    localparam int SW = $clog2(MAX_SUM);
    localparam int IW = $clog2(MAX_ITEMS);
    localparam int CW = $clog2(MAX_ITEMS + 1);
    localparam logic [17:0] START_MAX = 18'h3FFFF;

    typedef enum logic [11:0] {
        P_IDLE  = 12'h001, P_CLR   = 12'h002, P_URD   = 12'h004,
        P_UCHK  = 12'h008, P_SRD   = 12'h010, P_SCHK  = 12'h020,
        P_TRD   = 12'h040, P_TDUR  = 12'h080, P_TCHK  = 12'h100,
        P_ORD   = 12'h200, P_OUT   = 12'h400, P_DONE  = 12'h800
    } phase_t;

    phase_t             ph_reg, ph_next;
    logic [SW:0]        j_reg, j_next;
    logic [11:0]        dur_reg, dur_next;
    logic [CW-1:0]      cnt_reg, cnt_next;
    logic [IW-1:0]      k_reg, k_next;
    logic [CW-1:0]      i_reg, i_next;
    logic [6:0]         guard_reg, guard_next;
    logic [17:0]        sa_reg, sa_next, sb_reg, sb_next;
    logic [MAX_ITEMS-1:0] ga_reg, ga_next;

    logic               bm_we, bm_wd, bm_rd;
    logic [SW-1:0]      bm_wa, bm_ra;
    logic               fi_we;
    logic [SW-1:0]      fi_wa, fi_ra;
    logic [5:0]         fi_rd;
    logic               du_we;
    logic [IW-1:0]      du_wa, du_ra;
    logic [11:0]        du_rd;
    logic               bm_rd_hi;
    logic [SW-1:0]      eff_cap;
    logic [18:0]        sum_w;

    ssts_ram #(.WIDTH(1), .DEPTH(MAX_SUM)) u_bm (
        .clk(clk), .we(bm_we), .waddr(bm_wa), .wdata(bm_wd), .raddr(bm_ra), .rdata(bm_rd));
    ssts_ram #(.WIDTH(6), .DEPTH(MAX_SUM)) u_fi (
        .clk(clk), .we(fi_we), .waddr(fi_wa), .wdata(6'(k_reg)), .raddr(fi_ra), .rdata(fi_rd));
    ssts_ram #(.WIDTH(12), .DEPTH(MAX_ITEMS)) u_du (
        .clk(clk), .we(du_we), .waddr(du_wa), .wdata(duration), .raddr(du_ra), .rdata(du_rd));

    // A second bitmap copy gives the higher-sum bit in the same cycle.
    ssts_ram #(.WIDTH(1), .DEPTH(MAX_SUM)) u_bm2 (
        .clk(clk), .we(bm_we), .waddr(bm_wa), .wdata(bm_wd), .raddr(j_reg[SW-1:0]),
        .rdata(bm_rd_hi));

    assign eff_cap = (capacity > 12'(MAX_SUM - 1)) ? SW'(MAX_SUM - 1) : SW'(capacity);
    assign room    = cnt_reg < CW'(MAX_ITEMS);
    assign du_we   = accept && room;
    assign du_wa   = cnt_reg[IW-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ph_reg    <= P_CLR;
            j_reg     <= '0;
            cnt_reg   <= '0;
            ga_reg    <= '0;
            sa_reg    <= '0;
            sb_reg    <= '0;
        end
        else
        begin
            ph_reg    <= ph_next;
            j_reg     <= j_next;
            cnt_reg   <= cnt_next;
            ga_reg    <= ga_next;
            sa_reg    <= sa_next;
            sb_reg    <= sb_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dur_reg   <= dur_next;
        k_reg     <= k_next;
        i_reg     <= i_next;
        guard_reg <= guard_next;
    end

    always_comb
    begin
        ph_next    = ph_reg;
        j_next     = j_reg;
        dur_next   = dur_reg;
        cnt_next   = cnt_reg;
        k_next     = k_reg;
        i_next     = i_reg;
        guard_next = guard_reg;
        sa_next    = sa_reg;
        sb_next    = sb_reg;
        ga_next    = ga_reg;
        bm_we      = 1'b0;
        bm_wa      = j_reg[SW-1:0];
        bm_wd      = 1'b0;
        bm_ra      = '0;
        fi_we      = 1'b0;
        fi_wa      = j_reg[SW-1:0];
        fi_ra      = j_reg[SW-1:0];
        du_ra      = i_reg[IW-1:0];
        sts        = '0;
        sum_w      = '0;
        result_valid = 1'b0;
        item_index = '0;
        group      = 1'b0;
        start_time = '0;
        last_result = 1'b0;
        unique case (ph_reg)
            P_IDLE:
            begin
                if (cmd.upd_start)
                begin
                    k_next   = cnt_reg[IW-1:0];
                    cnt_next = cnt_reg + 1'b1;
                    dur_next = duration;
                    j_next   = {1'b0, eff_cap};
                    if (duration != 12'd0 && {1'b0, duration} <= {1'b0, 12'(eff_cap)})
                    begin
                        ph_next = P_URD;
                    end
                    else
                    begin
                        ph_next = P_DONE;
                    end
                end
                else if (cmd.fin_start)
                begin
                    j_next  = {1'b0, eff_cap};
                    ph_next = P_SRD;
                end
            end
            P_CLR:
            begin
                bm_we = 1'b1;
                bm_wa = j_reg[SW-1:0];
                bm_wd = (j_reg == '0);
                j_next = j_reg + 1'b1;
                if (j_reg == (SW+1)'(MAX_SUM - 1))
                begin
                    cnt_next = '0;
                    ga_next  = '0;
                    sa_next  = '0;
                    sb_next  = '0;
                    sts.clr_done = 1'b1;
                    ph_next  = P_IDLE;
                end
            end
            P_URD:
            begin
                bm_ra   = j_reg[SW-1:0] - SW'(dur_reg);
                ph_next = P_UCHK;
            end
            P_UCHK:
            begin
                if (!bm_rd_hi && bm_rd)
                begin
                    bm_we = 1'b1;
                    bm_wd = 1'b1;
                    fi_we = 1'b1;
                end
                if (j_reg[SW-1:0] == SW'(dur_reg))
                begin
                    ph_next = P_DONE;
                end
                else
                begin
                    j_next  = j_reg - 1'b1;
                    ph_next = P_URD;
                end
            end
            P_DONE:
            begin
                sts.upd_done = 1'b1;
                ph_next      = P_IDLE;
            end
            P_SRD:
            begin
                bm_ra   = j_reg[SW-1:0];
                ph_next = P_SCHK;
            end
            P_SCHK:
            begin
                if (j_reg == '0)
                begin
                    i_next  = '0;
                    ph_next = P_ORD;
                end
                else if (bm_rd)
                begin
                    guard_next = '0;
                    ph_next    = P_TRD;
                end
                else
                begin
                    j_next  = j_reg - 1'b1;
                    ph_next = P_SRD;
                end
            end
            P_TRD:
            begin
                fi_ra   = j_reg[SW-1:0];
                ph_next = P_TDUR;
            end
            P_TDUR:
            begin
                k_next  = fi_rd[IW-1:0];
                du_ra   = fi_rd[IW-1:0];
                ph_next = (7'(fi_rd) >= 7'(MAX_ITEMS)) ? P_ORD : P_TCHK;
                i_next  = '0;
            end
            P_TCHK:
            begin
                ga_next[k_reg] = 1'b1;
                guard_next = guard_reg + 1'b1;
                if (du_rd == 12'd0 || (SW+1)'(du_rd) > j_reg)
                begin
                    i_next  = '0;
                    ph_next = P_ORD;
                end
                else
                begin
                    j_next = j_reg - (SW+1)'(du_rd);
                    i_next = '0;
                    if (j_next == '0 || guard_next == 7'(MAX_ITEMS))
                    begin
                        ph_next = P_ORD;
                    end
                    else
                    begin
                        ph_next = P_TRD;
                    end
                end
            end
            P_ORD:
            begin
                du_ra = i_reg[IW-1:0];
                if (i_reg == cnt_reg)
                begin
                    sts.fin_done = 1'b1;
                    j_next       = '0;
                    ph_next      = P_CLR;
                end
                else
                begin
                    ph_next = P_OUT;
                end
            end
            P_OUT:
            begin
                result_valid = 1'b1;
                item_index   = 6'(i_reg);
                group        = !ga_reg[i_reg[IW-1:0]];
                start_time   = group ? sb_reg : sa_reg;
                last_result  = (i_reg + 1'b1) == cnt_reg;
                sum_w        = {1'b0, start_time} + 19'(du_rd);
                if (group)
                begin
                    sb_next = (sum_w > 19'(START_MAX)) ? START_MAX : sum_w[17:0];
                end
                else
                begin
                    sa_next = (sum_w > 19'(START_MAX)) ? START_MAX : sum_w[17:0];
                end
                i_next  = i_reg + 1'b1;
                ph_next = P_ORD;
            end
            default:
            begin
                ph_next = P_CLR;
            end
        endcase
    end
endmodule

// ----- rtl/core/subset_sum_two_way_split.sv -----
// Top level of the subset sum two-way split block.
// Channel  | Signals                         | Handshake
// input    | duration, last_item             | start high while busy low
// config   | cfg_valid, cfg_ready, cfg_data  | valid and ready
// result   | item_index, group, start_time,  | result_valid strobe, one cycle
//          | last_result                     |
// An item that updates sums walks the bitmap from capacity down to its duration,
// reading then checking each sum at the bitmap port; an item changing no sum skips it.
// The last item leads to a search down from capacity, traceback steps of read, duration
// and check, a read and an output step per result, then a MAX_SUM entry clearing pass.
// After reset the same MAX_SUM entry clearing pass runs with busy high.
// The receiver cannot stall; there is no ready on the result channel.
module subset_sum_two_way_split #(
    parameter int MAX_SUM   = 4096,
    parameter int MAX_ITEMS = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [11:0] duration,
    input  logic        last_item,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [11:0] cfg_data,
    output logic        result_valid,
    output logic [5:0]  item_index,
    output logic        group,
    output logic [17:0] start_time,
    output logic        last_result
);
    import ssts_pkg::*;

    ssts_cmd_t    cmd;
    ssts_status_t sts;
    logic [11:0]  capacity_reg;
    logic         room;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg <= '0;
        end
        else if (cfg_valid)
        begin
            capacity_reg <= cfg_data;
        end
    end

    ssts_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .start(start), .last_item(last_item), .room(room),
        .busy(busy), .cmd(cmd), .sts(sts));

    ssts_dp #(.MAX_SUM(MAX_SUM), .MAX_ITEMS(MAX_ITEMS)) u_dp (
        .clk(clk), .rst_n(rst_n), .capacity(capacity_reg), .duration(duration),
        .accept(start && !busy), .room(room), .cmd(cmd), .sts(sts),
        .result_valid(result_valid), .item_index(item_index), .group(group),
        .start_time(start_time), .last_result(last_result));

`ifndef SYNTHESIS
    a_no_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> busy) else $error("result while idle");
    a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(cmd)) else $error("multiple commands");
    a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && last_result) |=> !result_valid) else $error("result after last");
`endif
endmodule
